@@ rtl/lpfp_pkg.sv @@
// Shared types and constants for the length-prefixed frame parser.
// No dependencies.
package lpfp_pkg;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_DROP
    } phase_t;

    localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
    localparam logic [2:0] KIND_FRAME_OK   = 3'd1;
    localparam logic [2:0] KIND_BAD_HEADER = 3'd2;
    localparam logic [2:0] KIND_TOO_LONG   = 3'd3;
    localparam logic [2:0] KIND_BAD_TERM   = 3'd4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 21;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOWEST      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGHEST     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_KEY       = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAME_BYTES = 2'd3;

    localparam logic [7:0]  TERMINATOR     = 8'h5F;
    localparam logic [15:0] VERSION_ONE    = 16'd1;
    localparam int          SIZE_W         = 21;

    typedef struct packed {
        logic signed [15:0] key_lowest;
        logic signed [15:0] key_highest;
        logic signed [15:0] alpha_key;
        logic [SIZE_W-1:0]  max_frame_bytes;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         out_byte;
        logic signed [15:0] frame_key;
        logic               is_alpha;
    } result_t;

endpackage

@@ rtl/length_prefixed_frame_parser_core.sv @@
// Length-prefixed frame parser, top level. Depends on lpfp_pkg and the lpfp_* modules.
// An accepted byte lands in the input register; when the output register is free or being
// drained, the parser logic feeds its result into the result register.
// Throughput: one byte per cycle, limited only by output back-pressure.
// Reset (aresetn low, synchronous) clears the frame state, leaves drop mode and
// restores the configuration defaults.
module length_prefixed_frame_parser_core #(
    parameter int LENGTH_BYTES = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_in_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [2:0]                       m_kind,
    output logic [7:0]                       m_out_byte,
    output logic signed [15:0]               m_frame_key,
    output logic                             m_is_alpha,
    input  logic                             cfg_we,
    input  logic [lpfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lpfp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lpfp_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t m_res;
    logic    in_valid;
    logic    res_valid;
    logic    advance;
    logic    [7:0] in_byte;

    assign advance = in_valid && (!m_valid || m_ready);

    lpfp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lpfp_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_byte   (in_byte)
    );

    lpfp_parser #(
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .in_byte   (in_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    lpfp_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && res_valid),
        .res     (res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_res   (m_res)
    );

    assign m_kind      = m_res.kind;
    assign m_out_byte  = m_res.out_byte;
    assign m_frame_key = m_res.frame_key;
    assign m_is_alpha  = m_res.is_alpha;

endmodule

@@ rtl/lpfp_cfg_regs.sv @@
// Configuration register file for the frame parser.
// Depends on lpfp_pkg.
module lpfp_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [lpfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lpfp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output lpfp_pkg::cfg_t                     cfg
);
    import lpfp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_KEY_LOWEST:      cfg_next.key_lowest      = cfg_data[15:0];
                CFG_KEY_HIGHEST:     cfg_next.key_highest     = cfg_data[15:0];
                CFG_ALPHA_KEY:       cfg_next.alpha_key       = cfg_data[15:0];
                CFG_MAX_FRAME_BYTES: cfg_next.max_frame_bytes = cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.key_lowest      <= 16'sd0;
            cfg_reg.key_highest     <= 16'sd32767;
            cfg_reg.alpha_key       <= 16'sd0;
            cfg_reg.max_frame_bytes <= SIZE_W'(65536);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/lpfp_in_stage.sv @@
// Input register for the byte stream.
// Depends on nothing; advance comes from the top level.
module lpfp_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_in_byte;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

@@ rtl/lpfp_parser.sv @@
// Frame state machine: header assembly, checks, body count and terminator.
// Depends on lpfp_pkg.
module lpfp_parser #(
    parameter int LENGTH_BYTES = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        in_byte,
    input  lpfp_pkg::cfg_t    cfg,
    output logic              res_valid,
    output lpfp_pkg::result_t res
);
    import lpfp_pkg::*;

    localparam int HeaderSize = 4 + LENGTH_BYTES;
    localparam int CntW       = $clog2(HeaderSize);
    localparam logic [CntW-1:0] CntLast  = CntW'(HeaderSize - 1);
    localparam logic [CntW-1:0] CntKey   = CntW'(2);
    localparam logic [CntW-1:0] CntLen   = CntW'(4);
    localparam logic [SIZE_W:0] HdrBytes = (SIZE_W + 1)'(HeaderSize);

    phase_t              phase_reg,    phase_next;
    logic [CntW-1:0]     count_reg,    count_next;
    logic [15:0]         version_reg,  version_next;
    logic signed [15:0]  key_reg,      key_next;
    logic [SIZE_W-1:0]   len_low_reg,  len_low_next;
    logic                len_hi_reg,   len_hi_next;
    logic [SIZE_W-1:0]   body_left_reg, body_left_next;

    logic [2:0]          len_idx;
    logic [63:0]         shifted;
    logic [SIZE_W-1:0]   len_low_cur;
    logic                len_hi_cur;
    logic [SIZE_W:0]     frame_size;
    logic                bad_header;
    logic                too_long;
    logic                zero_len;

    assign len_idx     = 3'(count_reg - CntLen);
    assign shifted     = 64'(in_byte) << {len_idx, 3'b000};
    assign len_low_cur = len_low_reg | shifted[SIZE_W-1:0];
    assign len_hi_cur  = len_hi_reg | (|shifted[63:SIZE_W]);
    assign frame_size  = {1'b0, len_low_cur} + HdrBytes;
    assign bad_header  = (version_reg != VERSION_ONE)
                         || ($signed(key_reg) < $signed(cfg.key_lowest))
                         || ($signed(key_reg) > $signed(cfg.key_highest));
    assign too_long    = len_hi_cur || (frame_size > {1'b0, cfg.max_frame_bytes});
    assign zero_len    = !len_hi_cur && (len_low_cur == '0);

    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        version_next   = version_reg;
        key_next       = key_reg;
        len_low_next   = len_low_reg;
        len_hi_next    = len_hi_reg;
        body_left_next = body_left_reg;
        res_valid      = 1'b0;
        res            = '0;

        case (phase_reg)
            PH_HEADER: begin
                if (count_reg < CntKey) begin
                    if (count_reg[0]) version_next[15:8] = in_byte;
                    else              version_next[7:0]  = in_byte;
                end else if (count_reg < CntLen) begin
                    if (count_reg[0]) key_next[15:8] = in_byte;
                    else              key_next[7:0]  = in_byte;
                end else begin
                    len_low_next = len_low_cur;
                    len_hi_next  = len_hi_cur;
                end
                count_next = count_reg + 1'b1;
                if (count_reg == CntLast) begin
                    if (bad_header) begin
                        phase_next = PH_DROP;
                        res_valid  = 1'b1;
                        res.kind   = KIND_BAD_HEADER;
                    end else if (too_long) begin
                        phase_next = PH_DROP;
                        res_valid  = 1'b1;
                        res.kind   = KIND_TOO_LONG;
                    end else if (zero_len) begin
                        phase_next = PH_DROP;
                        res_valid  = 1'b1;
                        res.kind   = KIND_BAD_TERM;
                    end else begin
                        phase_next     = PH_BODY;
                        body_left_next = len_low_cur;
                    end
                end
            end
            PH_BODY: begin
                res_valid = 1'b1;
                if (body_left_reg > SIZE_W'(1)) begin
                    body_left_next = body_left_reg - 1'b1;
                    res.kind       = KIND_PAYLOAD;
                    res.out_byte   = in_byte;
                end else if (in_byte == TERMINATOR) begin
                    res.kind      = KIND_FRAME_OK;
                    res.frame_key = key_reg;
                    res.is_alpha  = (key_reg == cfg.alpha_key);
                    phase_next    = PH_HEADER;
                    count_next    = '0;
                    len_low_next  = '0;
                    len_hi_next   = 1'b0;
                end else begin
                    res.kind   = KIND_BAD_TERM;
                    phase_next = PH_DROP;
                end
            end
            PH_DROP: begin
            end
            default: begin
                phase_next = PH_DROP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            count_reg   <= '0;
            len_low_reg <= '0;
            len_hi_reg  <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            len_low_reg <= len_low_next;
            len_hi_reg  <= len_hi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            version_reg   <= version_next;
            key_reg       <= key_next;
            body_left_reg <= body_left_next;
        end
    end

endmodule

@@ rtl/lpfp_out_stage.sv @@
// Result register on the output channel.
// Depends on lpfp_pkg.
module lpfp_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  lpfp_pkg::result_t  res,
    input  logic               m_ready,
    output logic               m_valid,
    output lpfp_pkg::result_t  m_res
);
    import lpfp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

@@ sim/tb_length_prefixed_frame_parser_core.sv @@
// Self-checking testbench for length_prefixed_frame_parser_core: byte frames in, parsed items out,
// each item checked against an in-bench tracker of the frame state and config registers.
// Depends on lpfp_pkg and the parser RTL only.
module tb_length_prefixed_frame_parser_core;
    import lpfp_pkg::*;

    localparam int LEN_BYTES     = 8;
    localparam int HDR_BYTES     = 4 + LEN_BYTES;
    localparam int MAX_FRAME_TOP = 1048576;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int STALL_CYCLES  = 400;
    localparam int REPORT_LIMIT  = 10;
    localparam int CYCLE_LIMIT   = 200000;

    localparam cfg_t RESET_CFG = '{
        key_lowest:      16'sd0,
        key_highest:     16'sd32767,
        alpha_key:       16'sd0,
        max_frame_bytes: 21'd65536
    };

    typedef enum int {
        ERR_VERSION,
        ERR_KEY_LOW,
        ERR_KEY_HIGH,
        ERR_EMPTY_RANGE,
        ERR_SMALL_MAX,
        ERR_WIDE_LENGTH,
        ERR_ZERO_LENGTH,
        ERR_TERMINATOR
    } fault_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_in_byte = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [2:0]             m_kind;
    logic [7:0]             m_out_byte;
    logic signed [15:0]     m_frame_key;
    logic                   m_is_alpha;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // tracker of the parser
    cfg_t              shadow_cfg;
    phase_t            frame_phase;
    int                hdr_seen;
    logic [15:0]       got_version;
    logic [15:0]       got_key;
    logic [63:0]       got_length;
    logic [SIZE_W-1:0] body_remaining;
    result_t           parsed_items[$];

    int  feed_idle_pct  = 0;
    int  drain_idle_pct = 0;
    bit  stall_on       = 1'b0;
    bit  stall_request  = 1'b0;
    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  bytes_sent     = 0;
    int  results_seen   = 0;
    int  payload_seen   = 0;
    int  frames_seen    = 0;
    int  alpha_seen     = 0;
    int  reg_writes     = 0;
    int  leftover       = 0;
    logic [2:0] closing_kind = KIND_PAYLOAD;
    result_t    want_item;
    result_t    got_item;

    length_prefixed_frame_parser_core #(
        .LENGTH_BYTES(LEN_BYTES)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_out_byte (m_out_byte),
        .m_frame_key(m_frame_key),
        .m_is_alpha (m_is_alpha),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** length_prefixed_frame_parser_core: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= !stall_on && ($urandom_range(99) >= drain_idle_pct);
    end

    // long output hold-off, counted here
    always @(negedge aclk) begin
        if (stall_request) begin
            stall_on = 1'b1;
            repeat (STALL_CYCLES) @(negedge aclk);
            stall_on      = 1'b0;
            stall_request = 1'b0;
        end
    end

    // outputs are stable at the falling edge and taken at the next rising one
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_item.kind      = m_kind;
            got_item.out_byte  = m_out_byte;
            got_item.frame_key = m_frame_key;
            got_item.is_alpha  = m_is_alpha;
            results_seen++;
            if (parsed_items.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected item: kind %0d byte %02h key %0d alpha %0d",
                             got_item.kind, got_item.out_byte, $signed(got_item.frame_key),
                             got_item.is_alpha);
            end else begin
                want_item = parsed_items.pop_front();
                if (got_item.kind !== want_item.kind || got_item.out_byte !== want_item.out_byte ||
                    got_item.frame_key !== want_item.frame_key ||
                    got_item.is_alpha !== want_item.is_alpha) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"mismatch: want kind %0d byte %02h key %0d alpha %0d, ",
                                  "got kind %0d byte %02h key %0d alpha %0d"},
                                 want_item.kind, want_item.out_byte,
                                 $signed(want_item.frame_key), want_item.is_alpha,
                                 got_item.kind, got_item.out_byte,
                                 $signed(got_item.frame_key), got_item.is_alpha);
                end
            end
            case (got_item.kind)
                KIND_PAYLOAD: payload_seen++;
                KIND_FRAME_OK: begin
                    frames_seen++;
                    if (got_item.is_alpha)
                        alpha_seen++;
                end
                default: closing_kind = got_item.kind;
            endcase
        end
    end

    function automatic void clear_frame();
        frame_phase    = PH_HEADER;
        hdr_seen       = 0;
        got_version    = '0;
        got_key        = '0;
        got_length     = '0;
        body_remaining = '0;
    endfunction

    task automatic parse_stream_byte(input logic [7:0] b);
        result_t r;
        bit      emit;
        r    = '0;
        emit = 1'b0;
        case (frame_phase)
            PH_HEADER: begin
                if (hdr_seen < 2)
                    got_version[8*hdr_seen +: 8] = b;
                else if (hdr_seen < 4)
                    got_key[8*(hdr_seen-2) +: 8] = b;
                else
                    got_length[8*(hdr_seen-4) +: 8] = b;
                hdr_seen++;
                if (hdr_seen == HDR_BYTES) begin
                    emit = 1'b1;
                    if (got_version != VERSION_ONE ||
                        $signed(got_key) < $signed(shadow_cfg.key_lowest) ||
                        $signed(got_key) > $signed(shadow_cfg.key_highest)) begin
                        r.kind      = KIND_BAD_HEADER;
                        frame_phase = PH_DROP;
                    end else if (int'(shadow_cfg.max_frame_bytes) < HDR_BYTES ||
                                 got_length > 64'(int'(shadow_cfg.max_frame_bytes) - HDR_BYTES)) begin
                        r.kind      = KIND_TOO_LONG;
                        frame_phase = PH_DROP;
                    end else if (got_length == 0) begin
                        r.kind      = KIND_BAD_TERM;
                        frame_phase = PH_DROP;
                    end else begin
                        emit           = 1'b0;
                        body_remaining = got_length[SIZE_W-1:0];
                        frame_phase    = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                emit = 1'b1;
                if (body_remaining > 1) begin
                    body_remaining--;
                    r.kind     = KIND_PAYLOAD;
                    r.out_byte = b;
                end else if (b == TERMINATOR) begin
                    r.kind      = KIND_FRAME_OK;
                    r.frame_key = got_key;
                    r.is_alpha  = (got_key == shadow_cfg.alpha_key);
                    clear_frame();
                end else begin
                    r.kind         = KIND_BAD_TERM;
                    frame_phase    = PH_DROP;
                    body_remaining = '0;
                end
            end
            default: ;
        endcase
        if (emit)
            parsed_items.push_back(r);
    endtask

    task automatic put_byte(input logic [7:0] b);
        int gap;
        bit took;
        gap = 0;
        while ($urandom_range(99) < feed_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        parse_stream_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (parsed_items.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] word;
        word = value[CFG_DATA_W-1:0];
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_KEY_LOWEST:      shadow_cfg.key_lowest      = word[15:0];
            CFG_KEY_HIGHEST:     shadow_cfg.key_highest     = word[15:0];
            CFG_ALPHA_KEY:       shadow_cfg.alpha_key       = word[15:0];
            CFG_MAX_FRAME_BYTES: shadow_cfg.max_frame_bytes = word[SIZE_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_keys(input int lo, input int hi, input int alpha);
        write_reg(CFG_KEY_LOWEST, lo);
        write_reg(CFG_KEY_HIGHEST, hi);
        write_reg(CFG_ALPHA_KEY, alpha);
    endtask

    function automatic logic [7:0] payload_byte();
        if ($urandom_range(7) == 0)
            return TERMINATOR;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] pick_key();
        int lo, hi, alpha, k, choice;
        lo     = $signed(shadow_cfg.key_lowest);
        hi     = $signed(shadow_cfg.key_highest);
        alpha  = $signed(shadow_cfg.alpha_key);
        choice = $urandom_range(7);
        if (choice == 0)
            k = lo;
        else if (choice == 1)
            k = hi;
        else if (choice < 4 && alpha >= lo && alpha <= hi)
            k = alpha;
        else
            k = lo + int'($urandom_range(hi - lo));
        return k[15:0];
    endfunction

    task automatic send_header(input logic [15:0] version, input logic [15:0] key,
                               input logic [63:0] length);
        put_byte(version[7:0]);
        put_byte(version[15:8]);
        put_byte(key[7:0]);
        put_byte(key[15:8]);
        for (int i = 0; i < LEN_BYTES; i++)
            put_byte(length[8*i +: 8]);
    endtask

    task automatic send_good_frame(input logic [15:0] key, input int length);
        send_header(VERSION_ONE, key, 64'(length));
        repeat (length - 1) put_byte(payload_byte());
        put_byte(TERMINATOR);
    endtask

    task automatic test_reset_defaults();
        send_good_frame(16'd0, 1);
        send_header(VERSION_ONE, 16'h7FFF, 64'd4);
        put_byte(8'h00);
        put_byte(TERMINATOR);
        put_byte(8'hFF);
        put_byte(TERMINATOR);
        send_good_frame(pick_key(), 3);
    endtask

    task automatic test_key_extremes();
        set_keys(-32768, 32767, -32768);
        write_reg(CFG_MAX_FRAME_BYTES, MAX_FRAME_TOP);
        send_good_frame(16'h8000, 2);
        send_good_frame(16'h7FFF, 2);
        set_keys(32767, 32767, 32767);
        send_good_frame(16'h7FFF, 1);
        set_keys(-32768, -32768, 0);
        send_good_frame(16'h8000, 1);
        write_reg(CFG_MAX_FRAME_BYTES, HDR_BYTES + 1);
        send_good_frame(16'h8000, 1);
        set_keys(-5, 5, 3);
        write_reg(CFG_MAX_FRAME_BYTES, HDR_BYTES + 6);
        send_good_frame(16'd3, 6);
    endtask

    task automatic random_config();
        int lo, hi, t;
        lo = int'($urandom_range(65535)) - 32768;
        hi = int'($urandom_range(65535)) - 32768;
        if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        if ($urandom_range(3) == 0) begin
            lo = -32768;
            hi = 32767;
        end
        if ($urandom_range(3) == 0)
            set_keys(lo, hi, int'($urandom_range(65535)) - 32768);
        else
            set_keys(lo, hi, lo + int'($urandom_range(hi - lo)));
        if ($urandom_range(1) == 0)
            write_reg(CFG_MAX_FRAME_BYTES, HDR_BYTES + int'($urandom_range(24, 1)));
        else
            write_reg(CFG_MAX_FRAME_BYTES, int'($urandom_range(MAX_FRAME_TOP, 40)));
    endtask

    task automatic test_random_frames(input int n_bytes);
        int stop_at, lim, length;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            random_config();
            lim = int'(shadow_cfg.max_frame_bytes) - HDR_BYTES;
            if (lim > 24)
                lim = 24;
            repeat ($urandom_range(8, 3)) begin
                length = ($urandom_range(4) == 0) ? lim : int'($urandom_range(lim, 1));
                send_good_frame(pick_key(), length);
            end
        end
    endtask

    task automatic test_output_stall();
        write_reg(CFG_MAX_FRAME_BYTES, MAX_FRAME_TOP);
        stall_request = 1'b1;
        send_good_frame(pick_key(), 80);
        wait_drained();
    endtask

    task automatic test_fatal_error();
        fault_t      fault;
        logic [15:0] version;
        logic [63:0] length;
        fault   = fault_t'($urandom_range(ERR_TERMINATOR));
        version = VERSION_ONE;
        length  = 64'($urandom_range(10, 1));
        case (fault)
            ERR_VERSION: begin
                version = 16'($urandom_range(65535));
                if (version == VERSION_ONE)
                    version = '0;
            end
            ERR_KEY_LOW:     set_keys(1, 32767, 0);
            ERR_KEY_HIGH:    set_keys(-32768, -1, 0);
            ERR_EMPTY_RANGE: set_keys(1, 0, 0);
            ERR_SMALL_MAX:   write_reg(CFG_MAX_FRAME_BYTES, HDR_BYTES);
            ERR_WIDE_LENGTH: begin
                write_reg(CFG_MAX_FRAME_BYTES, MAX_FRAME_TOP);
                length = {32'($urandom_range(32'hFFFF_FFFF, 1)), 32'($urandom_range(15))};
            end
            ERR_ZERO_LENGTH: length = '0;
            default: ;
        endcase
        case (fault)
            ERR_KEY_LOW:     send_header(version, 16'($urandom_range(32768)) + 16'h8000, length);
            ERR_KEY_HIGH:    send_header(version, 16'($urandom_range(32767)), length);
            ERR_EMPTY_RANGE: send_header(version, 16'($urandom_range(65535)), length);
            ERR_TERMINATOR: begin
                send_header(version, pick_key(), length);
                repeat (int'(length) - 1) put_byte(payload_byte());
                put_byte(8'($urandom_range(255)) ^ (($urandom_range(1) == 0) ? 8'h00 : 8'h01)
                         | ((8'($urandom_range(255)) == TERMINATOR) ? 8'h80 : 8'h00));
            end
            default:         send_header(version, pick_key(), length);
        endcase
        // everything after the error is dropped
        repeat (30) put_byte(8'($urandom_range(255)));
        send_header(VERSION_ONE, 16'd0, 64'd1);
        put_byte(TERMINATOR);
        wait_drained();
    endtask

    initial begin
        shadow_cfg = RESET_CFG;
        clear_frame();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        feed_idle_pct  = 23;
        drain_idle_pct = 54;
        test_reset_defaults();
        test_random_frames(280);

        feed_idle_pct  = 54;
        drain_idle_pct = 23;
        test_key_extremes();
        test_random_frames(280);

        feed_idle_pct  = 0;
        drain_idle_pct = 0;
        test_random_frames(220);
        test_output_stall();
        test_fatal_error();

        s_valid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && parsed_items.size() != 0; w++)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        leftover = parsed_items.size();
        if (leftover != 0)
            $display("%0d expected items never arrived", leftover);

        $display("Sent %0d bytes over %0d register writes; checked %0d items: %0d payload bytes,",
                 bytes_sent, reg_writes, results_seen, payload_seen);
        $display("%0d good frames (%0d alpha), closing error kind %0d, one long output hold-off.",
                 frames_seen, alpha_seen, closing_kind);
        if (mismatch_count == 0 && leftover == 0)
            $display("** length_prefixed_frame_parser_core: PASSED **");
        else
            $display("** length_prefixed_frame_parser_core: FAILED **");
        $finish;
    end

endmodule
